// ===== design/dcs_pkg.sv =====
// ----------------------------------------------------------------------------
// dcs_pkg
// Shared types and constants for the distance constraint solver pipeline.
// ----------------------------------------------------------------------------
package dcs_pkg;

  localparam int POS_W    = 24;
  localparam int MASS_W   = 16;
  localparam int DIST_W   = 26;
  localparam int RAD_W    = 52;
  localparam int QDIR_W   = 17;
  localparam int W_W      = 17;
  localparam int PROD1_W  = 34;
  localparam int PROD2_W  = 60;
  localparam int CORR_W   = 28;
  localparam int SUM_W    = 29;

  localparam int IN_DATA_W  = 168;
  localparam int IN_USER_W  = 4;
  localparam int OUT_DATA_W = 96;

  // Stage map of the pipeline.
  localparam int ST_SQ    = 1;
  localparam int ST_SUM   = 2;
  localparam int ST_RT0   = 3;
  localparam int RT_STEPS = 26;
  localparam int ST_DIST  = ST_RT0 + RT_STEPS;
  localparam int ST_DV0   = ST_DIST + 1;
  localparam int DV_STEPS = 17;
  localparam int ST_WT    = ST_DV0 + DV_STEPS;
  localparam int ST_M1    = ST_WT + 1;
  localparam int ST_M2    = ST_M1 + 1;
  localparam int ST_ADD   = ST_M2 + 1;
  localparam int ST_SAT   = ST_ADD + 1;
  localparam int DEPTH    = ST_SAT + 1;

  localparam logic [W_W-1:0] W_HALF    = 17'd32768;
  localparam logic [W_W-1:0] W_ONE     = 17'd65536;
  localparam logic [11:0]    SOFT_COEF = 12'd3277;

  localparam logic [1:0] KIND_PUSH  = 2'd0;
  localparam logic [1:0] KIND_PULL  = 2'd1;
  localparam logic [1:0] KIND_RIGID = 2'd2;
  localparam logic [1:0] KIND_SOFT  = 2'd3;

  typedef struct packed {
    logic signed [POS_W-1:0] x1, y1, x2, y2;
    logic                    f1, f2;
    logic [1:0]              kind;
    logic [POS_W-1:0]        rest;
    logic [15:0]             dt;
    logic [MASS_W-1:0]       m1, m2;
    logic                    sx, sy;
    logic [POS_W:0]          ax, ay;
    logic [49:0]             sqx, sqy;
    logic [RAD_W-1:0]        rem, root;
    logic [DIST_W-1:0]       dlen;
    logic                    dneg;
    logic [DIST_W-1:0]       dmag;
    logic [41:0]             rx, ry;
    logic [QDIR_W-1:0]       qx, qy;
    logic [31:0]             r1, r2;
    logic [15:0]             q1, q2;
    logic                    ge1, ge2;
    logic [W_W-1:0]          w1, w2;
    logic                    apply;
    logic [PROD1_W-1:0]      pa, pb, pc, pd;
    logic [PROD2_W-1:0]      ca, cb, cc, cd;
    logic signed [SUM_W-1:0] n1x, n1y, n2x, n2y;
    logic signed [POS_W-1:0] o1x, o1y, o2x, o2y;
  } pipe_t;

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(2**(POS_W-1) - 1);
    lo = -SUM_W'(2**(POS_W-1));
    if (v > hi) begin
      sat_pos = hi[POS_W-1:0];
    end else if (v < lo) begin
      sat_pos = lo[POS_W-1:0];
    end else begin
      sat_pos = v[POS_W-1:0];
    end
  endfunction

endpackage

// ===== design/distance_constraint_solver.sv =====
// ----------------------------------------------------------------------------
// distance_constraint_solver
// Pipelined projection of one two-point distance constraint in fixed point.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Beat                   Contents
// s_axis    in   tvalid/tready/tdata    positions, masses, rest length, dt
//                tuser                  static flags and constraint kind
// m_axis    out  tvalid/tready/tdata    corrected positions
//                tuser                  applied flag
//
// One request can enter each cycle unless a stall at the output has backed
// up to the input. The depth is set by the 26-stage square root, one result
// bit per stage, and the 17-stage restoring divider that forms the unit
// direction and the mass ratios. Reset empties every stage. Each stage moves
// forward when it is empty or the stage after it moves, so bubbles close up
// and a stall at the output neither drops nor repeats a request.

module distance_constraint_solver (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // first_x, first_y, second_x, second_y, first_mass, second_mass,
  // rest_length, time_step
  input  logic [dcs_pkg::IN_DATA_W-1:0]  s_tdata,
  // first_fixed, second_fixed, kind
  input  logic [dcs_pkg::IN_USER_W-1:0]  s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // new_first_x, new_first_y, new_second_x, new_second_y
  output logic [dcs_pkg::OUT_DATA_W-1:0] m_tdata,
  // applied
  output logic                           m_tuser
);
  import dcs_pkg::*;

  pipe_t              st [DEPTH];
  logic [DEPTH-1:0]   v;
  logic [DEPTH-1:0]   en;

  // A stage may load when it is empty or its contents move on.
  always_comb begin
    en[DEPTH-1] = !v[DEPTH-1] || m_tready;
    for (int k = DEPTH - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign s_tready = en[0];

  // Stage 0 registers the request and forms the difference vector.
  pipe_t in0;
  logic signed [POS_W:0] dx0, dy0;

  always_comb begin
    in0       = '0;
    in0.x1    = s_tdata[23:0];
    in0.y1    = s_tdata[47:24];
    in0.x2    = s_tdata[71:48];
    in0.y2    = s_tdata[95:72];
    in0.m1    = s_tdata[111:96];
    in0.m2    = s_tdata[127:112];
    in0.rest  = s_tdata[151:128];
    in0.dt    = s_tdata[167:152];
    in0.f1    = s_tuser[0];
    in0.f2    = s_tuser[1];
    in0.kind  = s_tuser[3:2];
    dx0       = {in0.x1[POS_W-1], in0.x1} - {in0.x2[POS_W-1], in0.x2};
    dy0       = {in0.y1[POS_W-1], in0.y1} - {in0.y2[POS_W-1], in0.y2};
    in0.sx    = dx0[POS_W];
    in0.sy    = dy0[POS_W];
    in0.ax    = dx0[POS_W] ? -dx0 : dx0;
    in0.ay    = dy0[POS_W] ? -dy0 : dy0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en[0]) begin
      v[0] <= s_tvalid;
    end
    if (en[0]) begin
      st[0] <= in0;
    end
  end

  for (genvar k = 1; k < DEPTH; k++) begin : g_stage
    pipe_t s, nxt;
    assign s = st[k-1];

    if (k == ST_SQ) begin : g_sq
      always_comb begin
        nxt     = s;
        nxt.sqx = s.ax * s.ax;
        nxt.sqy = s.ay * s.ay;
      end
    end else if (k == ST_SUM) begin : g_sum
      always_comb begin
        nxt      = s;
        nxt.rem  = {2'b00, s.sqx} + {2'b00, s.sqy};
        nxt.root = '0;
      end
    end else if (k >= ST_RT0 && k < ST_DIST) begin : g_root
      // One result bit of the integer square root per stage.
      localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (50 - 2 * (k - ST_RT0));
      logic [RAD_W-1:0] trial;
      always_comb begin
        nxt   = s;
        trial = s.root + BIT;
        if (s.rem >= trial) begin
          nxt.rem  = s.rem - trial;
          nxt.root = (s.root >> 1) + BIT;
        end else begin
          nxt.root = s.root >> 1;
        end
      end
    end else if (k == ST_DIST) begin : g_dist
      logic [DIST_W-1:0] d;
      logic [DIST_W-1:0] r;
      always_comb begin
        nxt      = s;
        d        = s.root[DIST_W-1:0];
        r        = {2'b00, s.rest};
        nxt.dlen = d;
        nxt.dneg = d < r;
        nxt.dmag = (d < r) ? r - d : d - r;
        nxt.rx   = {1'b0, s.ax, 16'b0};
        nxt.ry   = {1'b0, s.ay, 16'b0};
        nxt.qx   = '0;
        nxt.qy   = '0;
        nxt.r1   = {s.m2, 16'b0};
        nxt.r2   = {s.m1, 16'b0};
        nxt.q1   = '0;
        nxt.q2   = '0;
        nxt.ge1  = s.m2 >= s.m1;
        nxt.ge2  = s.m1 >= s.m2;
      end
    end else if (k >= ST_DV0 && k < ST_WT) begin : g_div
      // Restoring division, quotient bit QB in this stage.
      localparam int QB = DV_STEPS - 1 - (k - ST_DV0);
      logic [41:0] dd;
      logic [31:0] d1, d2;
      always_comb begin
        nxt = s;
        dd  = {16'b0, s.dlen} << QB;
        d1  = {16'b0, s.m1} << QB;
        d2  = {16'b0, s.m2} << QB;
        if (s.rx >= dd) begin
          nxt.rx     = s.rx - dd;
          nxt.qx[QB] = 1'b1;
        end
        if (s.ry >= dd) begin
          nxt.ry     = s.ry - dd;
          nxt.qy[QB] = 1'b1;
        end
        if (QB < 16) begin
          if (s.r1 >= d1) begin
            nxt.r1                 = s.r1 - d1;
            nxt.q1[QB[3:0]]        = 1'b1;
          end
          if (s.r2 >= d2) begin
            nxt.r2                 = s.r2 - d2;
            nxt.q2[QB[3:0]]        = 1'b1;
          end
        end
      end
    end else if (k == ST_WT) begin : g_wt
      logic [27:0]       soft_w;
      logic [DIST_W-1:0] r;
      always_comb begin
        nxt    = s;
        r      = {2'b00, s.rest};
        soft_w = s.dt * SOFT_COEF + 28'(W_HALF);
        if (s.dlen == '0) begin
          nxt.qx = '0;
          nxt.qy = '0;
        end
        nxt.w1 = W_HALF;
        nxt.w2 = W_HALF;
        if (s.f1) begin
          nxt.w2 = W_ONE;
        end else if (s.f2) begin
          nxt.w1 = W_ONE;
        end else begin
          nxt.w1 = (s.ge1 || s.q1 > 16'd32768) ? W_HALF : {1'b0, s.q1};
          nxt.w2 = (s.ge2 || s.q2 > 16'd32768) ? W_HALF : {1'b0, s.q2};
        end
        case (s.kind)
          KIND_PUSH:  nxt.apply = s.dlen <= r;
          KIND_PULL:  nxt.apply = s.dlen >= r;
          KIND_RIGID: nxt.apply = s.dlen != r;
          default: begin
            nxt.apply = 1'b1;
            nxt.w1    = {5'b0, soft_w[27:16]};
            nxt.w2    = {5'b0, soft_w[27:16]};
          end
        endcase
      end
    end else if (k == ST_M1) begin : g_m1
      always_comb begin
        nxt    = s;
        nxt.pa = s.qx * s.w1;
        nxt.pb = s.qy * s.w1;
        nxt.pc = s.qx * s.w2;
        nxt.pd = s.qy * s.w2;
      end
    end else if (k == ST_M2) begin : g_m2
      always_comb begin
        nxt    = s;
        nxt.ca = s.pa * s.dmag;
        nxt.cb = s.pb * s.dmag;
        nxt.cc = s.pc * s.dmag;
        nxt.cd = s.pd * s.dmag;
      end
    end else if (k == ST_ADD) begin : g_add
      localparam logic [PROD2_W-1:0] RND = PROD2_W'(1) << 31;
      logic [PROD2_W-1:0]      ra, rb, rc, rd;
      logic signed [SUM_W-1:0] sa, sb, sc, sd;
      always_comb begin
        nxt = s;
        ra  = (s.ca + RND) >> 32;
        rb  = (s.cb + RND) >> 32;
        rc  = (s.cc + RND) >> 32;
        rd  = (s.cd + RND) >> 32;
        sa  = (s.sx ^ s.dneg) ? -$signed({1'b0, ra[CORR_W-1:0]})
                              :  $signed({1'b0, ra[CORR_W-1:0]});
        sb  = (s.sy ^ s.dneg) ? -$signed({1'b0, rb[CORR_W-1:0]})
                              :  $signed({1'b0, rb[CORR_W-1:0]});
        sc  = (s.sx ^ s.dneg) ? -$signed({1'b0, rc[CORR_W-1:0]})
                              :  $signed({1'b0, rc[CORR_W-1:0]});
        sd  = (s.sy ^ s.dneg) ? -$signed({1'b0, rd[CORR_W-1:0]})
                              :  $signed({1'b0, rd[CORR_W-1:0]});
        nxt.n1x = SUM_W'(s.x1);
        nxt.n1y = SUM_W'(s.y1);
        nxt.n2x = SUM_W'(s.x2);
        nxt.n2y = SUM_W'(s.y2);
        if (s.apply && !s.f1) begin
          nxt.n1x = SUM_W'(s.x1) - sa;
          nxt.n1y = SUM_W'(s.y1) - sb;
        end
        if (s.apply && !s.f2) begin
          nxt.n2x = SUM_W'(s.x2) + sc;
          nxt.n2y = SUM_W'(s.y2) + sd;
        end
      end
    end else begin : g_sat
      always_comb begin
        nxt     = s;
        nxt.o1x = sat_pos(s.n1x);
        nxt.o1y = sat_pos(s.n1y);
        nxt.o2x = sat_pos(s.n2x);
        nxt.o2y = sat_pos(s.n2y);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en[k]) begin
        v[k] <= v[k-1];
      end
      if (en[k]) begin
        st[k] <= nxt;
      end
    end
  end

  assign m_tvalid = v[DEPTH-1];
  assign m_tdata  = {st[DEPTH-1].o2y, st[DEPTH-1].o2x, st[DEPTH-1].o1y, st[DEPTH-1].o1x};
  assign m_tuser  = st[DEPTH-1].apply;

`ifndef SYNTH
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");
  a_skip_keeps: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !st[DEPTH-1].apply) |->
      (st[DEPTH-1].o1x == st[DEPTH-1].x1 && st[DEPTH-1].o2y == st[DEPTH-1].y2))
    else $error("skipped correction moved a point");
  a_static_first: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && st[DEPTH-1].f1) |->
      (st[DEPTH-1].o1x == st[DEPTH-1].x1 && st[DEPTH-1].o1y == st[DEPTH-1].y1))
    else $error("static first point moved");
  a_soft_applied: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && st[DEPTH-1].kind == KIND_SOFT) |-> m_tuser)
    else $error("soft constraint not applied");
  a_stall_holds_last: assert property (@(posedge clk) disable iff (rst)
    (v[DEPTH-1] && !m_tready && v[DEPTH-2]) |=> (v[DEPTH-1] && v[DEPTH-2]))
    else $error("stalled pipeline lost a request");
`endif

endmodule
